### design/rtss_pkg.sv
// Package for the resistive touch SPI sequencer: command words, slot limits,
// register indexes and the best-two averaging function.
// No dependencies.
package rtss_pkg;

    localparam int unsigned SampleW   = 13;
    localparam int unsigned CoordW    = 14;
    localparam int unsigned PressW    = 15;
    localparam int unsigned NumSample = 6;

    localparam logic [7:0]  StartByte     = 8'hB1;
    localparam logic [7:0]  LastShortSlot = 8'd71;
    localparam logic [7:0]  LastLongSlot  = 8'd151;
    localparam logic [7:0]  ByteSlots     = 8'd8;
    localparam logic [12:0] FullScale     = 13'd4095;
    localparam logic [7:0]  TickSat       = 8'd255;

    localparam logic [1:0]  RotationReset = 2'd0;
    localparam logic [13:0] ThresholdReset = 14'd300;
    localparam logic [7:0]  IntervalReset = 8'd3;

    // word positions in the command list
    localparam logic [4:0] WordZ1    = 5'd0;
    localparam logic [4:0] WordZ2    = 5'd1;
    localparam logic [4:0] WordFirst = 5'd3;
    localparam logic [4:0] WordLast  = 5'd8;
    localparam logic [4:0] ShortSkip = 5'd5;

    typedef enum logic [1:0] {
        CFG_ROTATION  = 2'd0,
        CFG_THRESHOLD = 2'd1,
        CFG_INTERVAL  = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        ROT_SWAP_FLIP_X = 2'd0,
        ROT_NATIVE      = 2'd1,
        ROT_SWAP_FLIP_Y = 2'd2,
        ROT_FLIP_BOTH   = 2'd3
    } rotation_t;

    function automatic logic [15:0] cmd_word(input logic [3:0] idx);
        logic [15:0] w;
        case (idx)
            4'd0:    w = 16'h00C1;
            4'd1:    w = 16'h0091;
            4'd2:    w = 16'h0091;
            4'd3:    w = 16'h00D1;
            4'd4:    w = 16'h0091;
            4'd5:    w = 16'h00D1;
            4'd6:    w = 16'h0091;
            4'd7:    w = 16'h00D0;
            default: w = 16'h0000;
        endcase
        return w;
    endfunction

    function automatic logic [SampleW-1:0] abs_diff(input logic [SampleW-1:0] a,
                                                    input logic [SampleW-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    // mean of the closest pair, rounded down; ties favour (a,b), then (a,c)
    function automatic logic [SampleW-1:0] best_two(input logic [SampleW-1:0] a,
                                                    input logic [SampleW-1:0] b,
                                                    input logic [SampleW-1:0] c);
        logic [SampleW-1:0] ab;
        logic [SampleW-1:0] ac;
        logic [SampleW-1:0] bc;
        logic [SampleW:0]   sum;
        ab = abs_diff(a, b);
        ac = abs_diff(a, c);
        bc = abs_diff(b, c);
        if (ab <= ac && ab <= bc)
        begin
            sum = {1'b0, a} + {1'b0, b};
        end
        else if (ac <= ab && ac <= bc)
        begin
            sum = {1'b0, a} + {1'b0, c};
        end
        else
        begin
            sum = {1'b0, b} + {1'b0, c};
        end
        return sum[SampleW:1];
    endfunction

endpackage

### design/resistive_touch_spi_sequencer_top.sv
// Top level of the resistive touch SPI sequencer: slot sequencer, pressure
// and coordinate filtering, output register. Depends on rtss_pkg.
//
// Usage:
//   Slave stream: one transfer per serial bit slot, tdata = {miso, ms_tick,
//   poll} in bits 2..0. A poll on an idle slot starts a read pass once
//   min_interval_ms ticks have been counted since the previous pass began.
//   Master stream: one transfer per accepted slot carrying the pin levels
//   for that slot (cs_n, mosi, sclk_pulse), busy, the stored touch state and
//   the filtered coordinates; tlast marks the final slot of a pass.
//   A short pass (no touch) lasts 72 slots, a long pass 152 slots.
//   Configuration: a separate write channel (cfg_valid/cfg_ready, cfg_addr,
//   cfg_data), always ready; write only while no pass is under way.
//   Timing: the result of a slot is registered and appears in the cycle after its transfer.
//   Throughput: one slot per clock while the result stream does not stall; the single
//   output register is refilled in the cycle it is emptied.
//   Reset: rst_n clears the sequencer, stored samples and coordinates and
//   loads rotation 0, threshold 300, interval 3.
//   Stall: when m_tready is low and the output register is full, s_tready
//   drops and the slot sequencer holds.
module resistive_touch_spi_sequencer_top
    import rtss_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // input slot stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] poll, [1] ms_tick, [2] miso, rest zero
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [0] cs_n, [1] mosi, [2] sclk_pulse, [3] busy_res,
                                   // [4] touched, [18:5] coord_x, [32:19] coord_y,
                                   // [46:33] pressure, [47] zero
    output logic        m_tlast,   // done_res
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_addr,
    input  logic [13:0] cfg_data
);

    // configuration registers
    logic [1:0]  rotation_reg;
    logic [13:0] threshold_reg;
    logic [7:0]  interval_reg;

    // sequencer state
    logic [7:0]                slot_reg,      slot_next;
    logic                      busy_reg,      busy_next;
    logic                      long_reg,      long_next;
    logic [15:0]               shift_reg,     shift_next;
    logic [SampleW-1:0]        plate_reg,     plate_next;
    logic signed [PressW-1:0]  pwork_reg,     pwork_next;
    logic [SampleW-1:0]        sample_reg  [NumSample];
    logic [SampleW-1:0]        sample_next [NumSample];
    logic [7:0]                ms_reg,        ms_next;
    logic signed [CoordW-1:0]  x_reg,         x_next;
    logic signed [CoordW-1:0]  y_reg,         y_next;
    logic [CoordW-1:0]         z_reg,         z_next;

    // output register
    logic        m_tvalid_reg;
    logic [47:0] m_tdata_reg,  m_tdata_next;
    logic        m_tlast_reg,  m_tlast_next;

    logic accept;
    logic poll, tick, miso;

    assign cfg_ready = 1'b1;
    assign s_tready  = !m_tvalid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign poll      = s_tdata[0];
    assign tick      = s_tdata[1];
    assign miso      = s_tdata[2];

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // one slot of the sequencer
    always_comb
    begin
        logic               start;
        logic               active;
        logic [7:0]         s;
        logic               lng;
        logic [7:0]         sub;
        logic [4:0]         eff;
        logic [3:0]         bitpos;
        logic [15:0]        word;
        logic [SampleW-1:0] val;
        logic [2:0]         sidx;
        logic               last;
        logic               mosi, done;
        logic signed [PressW-1:0] pclamp;
        logic [SampleW-1:0] xa, ya;
        logic signed [CoordW-1:0] xs, ys, xi, yi;
        logic               touched;

        start  = !busy_reg && poll && (ms_reg >= interval_reg);
        active = busy_reg || start;
        s      = start ? 8'd0 : slot_reg;
        lng    = start ? 1'b0 : long_reg;

        // hold by default
        slot_next  = slot_reg;
        busy_next  = active;
        long_next  = lng;
        shift_next = start ? 16'd0 : shift_reg;
        plate_next = plate_reg;
        pwork_next = pwork_reg;
        for (int i = 0; i < NumSample; i++)
        begin
            sample_next[i] = start ? '0 : sample_reg[i];
        end
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;

        // millisecond counter: restart on a pass start, else count and saturate
        if (start)
        begin
            ms_next = 8'd0;
        end
        else if (tick && ms_reg != TickSat)
        begin
            ms_next = ms_reg + 8'd1;
        end
        else
        begin
            ms_next = ms_reg;
        end

        mosi   = 1'b0;
        done   = 1'b0;
        sub    = s - ByteSlots;
        bitpos = sub[3:0];
        eff    = {1'b0, sub[7:4]};
        if (!lng && eff >= 5'd2)
        begin
            eff = eff + ShortSkip;
        end
        if (eff > WordLast)
        begin
            eff = WordLast;
        end
        word   = cmd_word(eff[3:0]);
        sidx   = 3'(eff - WordFirst);
        pclamp = '0;
        xa     = '0;
        ya     = '0;
        xs     = '0;
        ys     = '0;
        xi     = '0;
        yi     = '0;
        val    = '0;
        last   = 1'b0;

        if (active)
        begin
            shift_next = {shift_next[14:0], miso};
            val        = shift_next[15:3];
            if (s < ByteSlots)
            begin
                mosi = StartByte[3'(7 - s[2:0])];
            end
            else
            begin
                mosi = word[4'(15 - bitpos)];
                if (bitpos == 4'd15)
                begin
                    if (eff == WordZ1)
                    begin
                        plate_next = val;
                    end
                    else if (eff == WordZ2)
                    begin
                        pwork_next = signed'({2'b00, plate_next})
                                   + signed'({2'b00, FullScale})
                                   - signed'({2'b00, val});
                        long_next  = pwork_next >= signed'({1'b0, threshold_reg});
                    end
                    else if (eff >= WordFirst)
                    begin
                        sample_next[sidx] = val;
                    end
                end
            end

            last = s >= (long_next ? LastLongSlot : LastShortSlot);
            if (last)
            begin
                done      = 1'b1;
                busy_next = 1'b0;
                slot_next = 8'd0;
                pclamp    = pwork_next[PressW-1] ? '0 : pwork_next;
                if (pclamp < signed'({1'b0, threshold_reg}))
                begin
                    z_next = '0;
                end
                else
                begin
                    xa = best_two(sample_next[0], sample_next[2], sample_next[4]);
                    ya = best_two(sample_next[1], sample_next[3], sample_next[5]);
                    xs = signed'({1'b0, xa});
                    ys = signed'({1'b0, ya});
                    xi = signed'({1'b0, FullScale}) - xs;
                    yi = signed'({1'b0, FullScale}) - ys;
                    z_next = pclamp[CoordW-1:0];
                    case (rotation_t'(rotation_reg))
                        ROT_SWAP_FLIP_X:
                        begin
                            x_next = yi;
                            y_next = xs;
                        end
                        ROT_NATIVE:
                        begin
                            x_next = xs;
                            y_next = ys;
                        end
                        ROT_SWAP_FLIP_Y:
                        begin
                            x_next = ys;
                            y_next = xi;
                        end
                        default:
                        begin
                            x_next = xi;
                            y_next = yi;
                        end
                    endcase
                end
            end
            else
            begin
                slot_next = s + 8'd1;
            end
        end

        touched = z_next >= threshold_reg;
        m_tlast_next = done;
        m_tdata_next = {1'b0, z_next, y_next, x_next, touched,
                        active, active, mosi, !active};
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rotation_reg  <= RotationReset;
            threshold_reg <= ThresholdReset;
            interval_reg  <= IntervalReset;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index_t'(cfg_addr))
                CFG_ROTATION:  rotation_reg  <= cfg_data[1:0];
                CFG_THRESHOLD: threshold_reg <= cfg_data;
                CFG_INTERVAL:  interval_reg  <= cfg_data[7:0];
                default:       ;
            endcase
        end
    end

    // sequencer state: advance on each accepted slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg  <= '0;
            busy_reg  <= 1'b0;
            long_reg  <= 1'b0;
            shift_reg <= '0;
            plate_reg <= '0;
            pwork_reg <= '0;
            for (int i = 0; i < NumSample; i++)
            begin
                sample_reg[i] <= '0;
            end
            ms_reg <= '0;
            x_reg  <= '0;
            y_reg  <= '0;
            z_reg  <= '0;
        end
        else if (accept)
        begin
            slot_reg  <= slot_next;
            busy_reg  <= busy_next;
            long_reg  <= long_next;
            shift_reg <= shift_next;
            plate_reg <= plate_next;
            pwork_reg <= pwork_next;
            for (int i = 0; i < NumSample; i++)
            begin
                sample_reg[i] <= sample_next[i];
            end
            ms_reg <= ms_next;
            x_reg  <= x_next;
            y_reg  <= y_next;
            z_reg  <= z_next;
        end
    end

    // output register: load on accept, drop valid once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (accept)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            m_tdata_reg <= m_tdata_next;
            m_tlast_reg <= m_tlast_next;
        end
    end

endmodule
